@@ sv/itchd_pkg.sv @@
// Package for the ITCH message decoder: captured-field and decoded-record types,
// message type characters, minimum body lengths, kind codes and statistic indexes.
// No dependencies.
package itchd_pkg;

  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_U     = 8'h55;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [15:0] MIN_LEN_R = 16'd39;
  localparam logic [15:0] MIN_LEN_A = 16'd36;
  localparam logic [15:0] MIN_LEN_F = 16'd40;
  localparam logic [15:0] MIN_LEN_E = 16'd31;
  localparam logic [15:0] MIN_LEN_C = 16'd36;
  localparam logic [15:0] MIN_LEN_X = 16'd23;
  localparam logic [15:0] MIN_LEN_D = 16'd19;
  localparam logic [15:0] MIN_LEN_U = 16'd35;

  localparam logic [2:0] KIND_IGNORED   = 3'd0;
  localparam logic [2:0] KIND_DIRECTORY = 3'd1;
  localparam logic [2:0] KIND_ADD       = 3'd2;
  localparam logic [2:0] KIND_EXEC      = 3'd3;
  localparam logic [2:0] KIND_EXEC_PX   = 3'd4;
  localparam logic [2:0] KIND_CANCEL    = 3'd5;
  localparam logic [2:0] KIND_DELETE    = 3'd6;
  localparam logic [2:0] KIND_REPLACE   = 3'd7;

  localparam int NUM_STATS = 7;
  localparam logic [2:0] ST_MSG = 3'd0;
  localparam logic [2:0] ST_ADD = 3'd1;
  localparam logic [2:0] ST_EXE = 3'd2;
  localparam logic [2:0] ST_TRD = 3'd3;
  localparam logic [2:0] ST_CAN = 3'd4;
  localparam logic [2:0] ST_DEL = 3'd5;
  localparam logic [2:0] ST_REP = 3'd6;

  typedef struct packed {
    logic [7:0]  type_byte;
    logic [15:0] body_length;
    logic [15:0] locate;
    logic [63:0] first_ref;
    logic [63:0] second_ref;
    logic [7:0]  side_byte;
    logic [31:0] shares;
    logic [31:0] price;
  } capture_t;

  typedef struct packed {
    logic [2:0]  msg_kind;
    logic        has_mpid;
    logic [15:0] stock_locate;
    logic [63:0] order_ref;
    logic [63:0] new_order_ref;
    logic        sell_side;
    logic [31:0] share_count;
    logic [31:0] order_price;
    logic [63:0] symbol_text;
    logic [3:0]  symbol_length;
    logic        stat_en;
    logic [2:0]  stat_idx;
    logic        trade_en;
  } record_t;

endpackage

@@ sv/itch_message_decoder_top.sv @@
// ITCH message decoder top level: accepts one stream byte per cycle and returns one
// decoded record per nonempty message. The last body byte sets the parser's msg_valid
// and then out_valid in itchd_stats. Throughput is one byte per cycle; in_ready falls
// only while a finished record is held behind a stalled output. Synchronous reset
// returns the parser to the first length byte and clears all statistics counters.
// Depends on itchd_pkg, itchd_parser, itchd_decode and itchd_stats.
module itch_message_decoder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  msg_kind,
  output logic        has_mpid,
  output logic [15:0] stock_locate,
  output logic [63:0] order_ref,
  output logic [63:0] new_order_ref,
  output logic        sell_side,
  output logic [31:0] share_count,
  output logic [31:0] order_price,
  output logic [63:0] symbol_text,
  output logic [3:0]  symbol_length,
  output logic [31:0] message_total,
  output logic [31:0] kind_total
);
  import itchd_pkg::*;

  capture_t msg;
  logic     msg_valid;
  logic     msg_ready;
  record_t  rec;
  record_t  result;

  itchd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .msg_valid (msg_valid),
    .msg_ready (msg_ready),
    .msg       (msg)
  );

  itchd_decode u_decode (
    .msg (msg),
    .rec (rec)
  );

  itchd_stats u_stats (
    .clk           (clk),
    .rst           (rst),
    .rec_valid     (msg_valid),
    .rec_ready     (msg_ready),
    .rec           (rec),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result        (result),
    .message_total (message_total),
    .kind_total    (kind_total)
  );

  assign msg_kind      = result.msg_kind;
  assign has_mpid      = result.has_mpid;
  assign stock_locate  = result.stock_locate;
  assign order_ref     = result.order_ref;
  assign new_order_ref = result.new_order_ref;
  assign sell_side     = result.sell_side;
  assign share_count   = result.share_count;
  assign order_price   = result.order_price;
  assign symbol_text   = result.symbol_text;
  assign symbol_length = result.symbol_length;

endmodule

@@ sv/itchd_parser.sv @@
// Byte-level parser of the ITCH decoder: length header, body position and field capture.
// Raises a pending-message flag that holds until the result stage takes it.
// Depends on itchd_pkg.
module itchd_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  output logic               msg_valid,
  input  logic               msg_ready,
  output itchd_pkg::capture_t msg
);
  import itchd_pkg::*;

  typedef enum logic [2:0] {
    PH_LEN_HI = 3'b001,
    PH_LEN_LO = 3'b010,
    PH_BODY   = 3'b100
  } phase_t;

  phase_t      phase;
  logic [15:0] position;
  capture_t    cap;
  logic        accept;
  logic        last_byte;
  logic        msg_done;
  logic        is_add;
  logic        shares_win;
  logic        price_win;

  function automatic logic in_win(input logic [15:0] pos, input logic [15:0] lo,
                                  input logic [15:0] hi);
    in_win = (pos >= lo) && (pos <= hi);
  endfunction

  assign in_ready  = !msg_valid || msg_ready;
  assign accept    = in_valid && in_ready;
  assign last_byte = ({1'b0, position} + 17'd1) >= {1'b0, cap.body_length};
  assign msg_done  = accept && (phase == PH_BODY) && last_byte;
  assign msg       = cap;

  assign is_add     = (cap.type_byte == CH_A) || (cap.type_byte == CH_F);
  assign shares_win = (is_add && in_win(position, 16'd20, 16'd23)) ||
                      (((cap.type_byte == CH_E) || (cap.type_byte == CH_C) ||
                        (cap.type_byte == CH_X)) && in_win(position, 16'd19, 16'd22)) ||
                      ((cap.type_byte == CH_U) && in_win(position, 16'd27, 16'd30));
  assign price_win  = (is_add && in_win(position, 16'd32, 16'd35)) ||
                      ((cap.type_byte == CH_U) && in_win(position, 16'd31, 16'd34));

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_LEN_HI;
      position  <= '0;
      msg_valid <= 1'b0;
    end else begin
      if (msg_done) begin
        msg_valid <= 1'b1;
      end else if (msg_ready) begin
        msg_valid <= 1'b0;
      end
      if (accept) begin
        unique case (phase)
          PH_LEN_HI: begin
            phase <= PH_LEN_LO;
          end
          PH_LEN_LO: begin
            position <= '0;
            phase    <= ({cap.body_length[15:8], data_byte} == 16'd0) ? PH_LEN_HI : PH_BODY;
          end
          PH_BODY: begin
            if (last_byte) begin
              phase    <= PH_LEN_HI;
              position <= '0;
            end else begin
              position <= position + 16'd1;
            end
          end
          default: begin
            phase <= PH_LEN_HI;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      case (phase)
        PH_LEN_HI: begin
          cap.body_length <= {data_byte, 8'h00};
        end
        PH_LEN_LO: begin
          cap.body_length <= {cap.body_length[15:8], data_byte};
        end
        PH_BODY: begin
          if (position == 16'd0) begin
            cap.type_byte  <= data_byte;
            cap.locate     <= '0;
            cap.first_ref  <= '0;
            cap.second_ref <= '0;
            cap.side_byte  <= '0;
            cap.shares     <= '0;
            cap.price      <= '0;
          end else begin
            if (in_win(position, 16'd1, 16'd2)) begin
              cap.locate <= {cap.locate[7:0], data_byte};
            end
            if (in_win(position, 16'd11, 16'd18)) begin
              cap.first_ref <= {cap.first_ref[55:0], data_byte};
            end
            if (in_win(position, 16'd19, 16'd26)) begin
              cap.second_ref <= {cap.second_ref[55:0], data_byte};
            end
            if (position == 16'd19) begin
              cap.side_byte <= data_byte;
            end
            if (shares_win) begin
              cap.shares <= {cap.shares[23:0], data_byte};
            end
            if (price_win) begin
              cap.price <= {cap.price[23:0], data_byte};
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ sv/itchd_decode.sv @@
// Message decode of the ITCH decoder: picks the kind from type and length and
// selects the fields that kind carries. Depends on itchd_pkg.
module itchd_decode (
  input  itchd_pkg::capture_t msg,
  output itchd_pkg::record_t  rec
);
  import itchd_pkg::*;

  logic [2:0] kind;
  logic [3:0] sym_len;
  logic       nonspace_seen;

  always_comb begin
    kind = KIND_IGNORED;
    unique case (msg.type_byte)
      CH_R: if (msg.body_length >= MIN_LEN_R) kind = KIND_DIRECTORY;
      CH_A: if (msg.body_length >= MIN_LEN_A) kind = KIND_ADD;
      CH_F: if (msg.body_length >= MIN_LEN_F) kind = KIND_ADD;
      CH_E: if (msg.body_length >= MIN_LEN_E) kind = KIND_EXEC;
      CH_C: if (msg.body_length >= MIN_LEN_C) kind = KIND_EXEC_PX;
      CH_X: if (msg.body_length >= MIN_LEN_X) kind = KIND_CANCEL;
      CH_D: if (msg.body_length >= MIN_LEN_D) kind = KIND_DELETE;
      CH_U: if (msg.body_length >= MIN_LEN_U) kind = KIND_REPLACE;
      default: kind = KIND_IGNORED;
    endcase
  end

  // Trailing spaces sit in the low-order bytes of the symbol.
  always_comb begin
    sym_len       = 4'd8;
    nonspace_seen = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!nonspace_seen) begin
        if (msg.first_ref[8*i +: 8] == CH_SPACE) begin
          sym_len = sym_len - 4'd1;
        end else begin
          nonspace_seen = 1'b1;
        end
      end
    end
  end

  always_comb begin
    rec          = '0;
    rec.msg_kind = kind;
    unique case (kind) inside
      KIND_DIRECTORY: begin
        rec.stock_locate  = msg.locate;
        rec.symbol_text   = msg.first_ref;
        rec.symbol_length = sym_len;
      end
      KIND_ADD: begin
        rec.has_mpid     = (msg.type_byte == CH_F);
        rec.stock_locate = msg.locate;
        rec.order_ref    = msg.first_ref;
        rec.sell_side    = (msg.side_byte != CH_B);
        rec.share_count  = msg.shares;
        rec.order_price  = msg.price;
        rec.stat_en      = 1'b1;
        rec.stat_idx     = ST_ADD;
      end
      KIND_EXEC, KIND_EXEC_PX: begin
        rec.order_ref   = msg.first_ref;
        rec.share_count = msg.shares;
        rec.stat_en     = 1'b1;
        rec.stat_idx    = ST_EXE;
        rec.trade_en    = 1'b1;
      end
      KIND_CANCEL: begin
        rec.order_ref   = msg.first_ref;
        rec.share_count = msg.shares;
        rec.stat_en     = 1'b1;
        rec.stat_idx    = ST_CAN;
      end
      KIND_DELETE: begin
        rec.order_ref = msg.first_ref;
        rec.stat_en   = 1'b1;
        rec.stat_idx  = ST_DEL;
      end
      KIND_REPLACE: begin
        rec.order_ref     = msg.first_ref;
        rec.new_order_ref = msg.second_ref;
        rec.share_count   = msg.shares;
        rec.order_price   = msg.price;
        rec.stat_en       = 1'b1;
        rec.stat_idx      = ST_REP;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ sv/itchd_stats.sv @@
// Statistics counters and result register of the ITCH decoder.
// Takes a decoded record, bumps the wrapping counters and holds the result until transfer.
// Depends on itchd_pkg.
module itchd_stats (
  input  logic               clk,
  input  logic               rst,
  input  logic               rec_valid,
  output logic               rec_ready,
  input  itchd_pkg::record_t rec,
  output logic               out_valid,
  input  logic               out_ready,
  output itchd_pkg::record_t result,
  output logic [31:0]        message_total,
  output logic [31:0]        kind_total
);
  import itchd_pkg::*;

  logic [31:0] counters [NUM_STATS];
  logic        take;
  logic [31:0] msg_next;
  logic [31:0] kind_next;
  logic [31:0] trade_next;

  assign rec_ready  = !out_valid || out_ready;
  assign take       = rec_valid && rec_ready;
  assign msg_next   = counters[ST_MSG] + 32'd1;
  assign kind_next  = counters[rec.stat_idx] + 32'd1;
  assign trade_next = counters[ST_TRD] + 32'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_STATS; i++) begin
        counters[i] <= '0;
      end
    end else begin
      if (take) begin
        out_valid        <= 1'b1;
        counters[ST_MSG] <= msg_next;
        if (rec.stat_en) begin
          counters[rec.stat_idx] <= kind_next;
        end
        if (rec.trade_en) begin
          counters[ST_TRD] <= trade_next;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result        <= rec;
      message_total <= msg_next;
      kind_total    <= rec.stat_en ? kind_next : 32'd0;
    end
  end

endmodule

@@ sv/itchd_checker.sv @@
// Port-level checker for the ITCH message decoder, bound to the top level.
// Depends on itchd_pkg and itch_message_decoder_top.
module itchd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  msg_kind,
  input logic        has_mpid,
  input logic [15:0] stock_locate,
  input logic [63:0] symbol_text,
  input logic [3:0]  symbol_length,
  input logic [31:0] message_total,
  input logic [31:0] kind_total
);
  import itchd_pkg::*;

  a_reset_clears_output: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  a_stall_holds_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_stall_holds_total: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(message_total))
    else $error("message_total changed while stalled");

  a_ignored_fields_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && msg_kind == KIND_IGNORED |->
      kind_total == 32'd0 && !has_mpid && stock_locate == 16'd0)
    else $error("ignored message carries fields");

  a_symbol_only_directory: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> symbol_length <= 4'd8 &&
      (msg_kind == KIND_DIRECTORY || (symbol_length == 4'd0 && symbol_text == 64'd0)))
    else $error("symbol fields invalid");

endmodule

bind itch_message_decoder_top itchd_checker u_itchd_checker (.*);

@@ tb/sv/itch_message_decoder_top_test.sv @@
// Self-checking testbench for itch_message_decoder_top: drives a length-prefixed byte
// stream and compares every decoded record with a cycle-free model of the decoder.
// Depends on itchd_pkg and the itch_message_decoder_top RTL.
module itch_message_decoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import itchd_pkg::*;

  localparam int RANDOM_BYTES = 720;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int FILL_RANDOM  = 0;
  localparam int FILL_ZERO    = 1;
  localparam int FILL_ONES    = 2;

  typedef enum logic [2:0] {
    LEN_HIGH = 3'b001,
    LEN_LOW  = 3'b010,
    IN_BODY  = 3'b100
  } parse_phase_t;

  typedef struct packed {
    logic [2:0]  msg_kind;
    logic        has_mpid;
    logic [15:0] stock_locate;
    logic [63:0] order_ref;
    logic [63:0] new_order_ref;
    logic        sell_side;
    logic [31:0] share_count;
    logic [31:0] order_price;
    logic [63:0] symbol_text;
    logic [3:0]  symbol_length;
    logic [31:0] message_total;
    logic [31:0] kind_total;
  } decoded_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  msg_kind;
  logic        has_mpid;
  logic [15:0] stock_locate;
  logic [63:0] order_ref;
  logic [63:0] new_order_ref;
  logic        sell_side;
  logic [31:0] share_count;
  logic [31:0] order_price;
  logic [63:0] symbol_text;
  logic [3:0]  symbol_length;
  logic [31:0] message_total;
  logic [31:0] kind_total;

  logic [7:0] stream_bytes [$];
  logic [7:0] body_buf [$];
  decoded_t   expected_records [$];

  parse_phase_t phase = LEN_HIGH;
  logic [15:0]  body_len = '0;
  logic [15:0]  pos = '0;
  logic [7:0]   mtype = '0;
  logic [15:0]  locate = '0;
  logic [63:0]  ref_old = '0;
  logic [63:0]  ref_new = '0;
  logic [7:0]   side_chr = '0;
  logic [31:0]  shares = '0;
  logic [31:0]  price = '0;
  logic [63:0]  symbol = '0;
  logic [31:0]  stat_count [0:NUM_STATS-1];

  logic in_taken = 1'b0;
  int   bytes_queued = 0;
  int   bytes_taken = 0;
  int   records_checked = 0;
  int   mismatches = 0;
  int   stall_cycles = 0;
  int   kind_hits [0:7];
  logic may_idle;

  itch_message_decoder_top DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .msg_kind      (msg_kind),
    .has_mpid      (has_mpid),
    .stock_locate  (stock_locate),
    .order_ref     (order_ref),
    .new_order_ref (new_order_ref),
    .sell_side     (sell_side),
    .share_count   (share_count),
    .order_price   (order_price),
    .symbol_text   (symbol_text),
    .symbol_length (symbol_length),
    .message_total (message_total),
    .kind_total    (kind_total)
  );

  always #5 clk = ~clk;

  task automatic decode_byte(input logic [7:0] b);
    decoded_t   rec;
    logic       is_add;
    logic       bump;
    logic [2:0] sidx;
    logic       trimming;
    int         n;
    int         i;
    case (phase)
      LEN_HIGH: begin
        body_len = {b, 8'h00};
        phase = LEN_LOW;
      end
      LEN_LOW: begin
        body_len[7:0] = b;
        pos = '0;
        phase = (body_len == 16'd0) ? LEN_HIGH : IN_BODY;
      end
      default: begin
        if (pos == 16'd0) begin
          mtype = b;
          locate = '0;
          ref_old = '0;
          ref_new = '0;
          side_chr = '0;
          shares = '0;
          price = '0;
          symbol = '0;
        end else begin
          is_add = (mtype == CH_A) || (mtype == CH_F);
          if (pos >= 1 && pos <= 2) locate = {locate[7:0], b};
          if (pos >= 11 && pos <= 18) begin
            ref_old = {ref_old[55:0], b};
            symbol = {symbol[55:0], b};
          end
          if (pos >= 19 && pos <= 26) ref_new = {ref_new[55:0], b};
          if (pos == 19) side_chr = b;
          if ((is_add && pos >= 20 && pos <= 23) ||
              ((mtype == CH_E || mtype == CH_C || mtype == CH_X) && pos >= 19 && pos <= 22) ||
              (mtype == CH_U && pos >= 27 && pos <= 30))
            shares = {shares[23:0], b};
          if ((is_add && pos >= 32 && pos <= 35) || (mtype == CH_U && pos >= 31 && pos <= 34))
            price = {price[23:0], b};
        end
        if (32'(pos) + 32'd1 >= 32'(body_len)) begin
          rec = '0;
          bump = 1'b0;
          sidx = ST_MSG;
          stat_count[ST_MSG] = stat_count[ST_MSG] + 32'd1;
          rec.msg_kind = KIND_IGNORED;
          case (mtype)
            CH_R: if (body_len >= MIN_LEN_R) rec.msg_kind = KIND_DIRECTORY;
            CH_A: if (body_len >= MIN_LEN_A) rec.msg_kind = KIND_ADD;
            CH_F: if (body_len >= MIN_LEN_F) rec.msg_kind = KIND_ADD;
            CH_E: if (body_len >= MIN_LEN_E) rec.msg_kind = KIND_EXEC;
            CH_C: if (body_len >= MIN_LEN_C) rec.msg_kind = KIND_EXEC_PX;
            CH_X: if (body_len >= MIN_LEN_X) rec.msg_kind = KIND_CANCEL;
            CH_D: if (body_len >= MIN_LEN_D) rec.msg_kind = KIND_DELETE;
            CH_U: if (body_len >= MIN_LEN_U) rec.msg_kind = KIND_REPLACE;
            default: rec.msg_kind = KIND_IGNORED;
          endcase
          case (rec.msg_kind) inside
            KIND_DIRECTORY: begin
              n = 8;
              trimming = 1'b1;
              for (i = 0; i < 8; i++) begin
                if (trimming) begin
                  if (symbol[8*i +: 8] == CH_SPACE) n = n - 1;
                  else trimming = 1'b0;
                end
              end
              rec.stock_locate = locate;
              rec.symbol_text = symbol;
              rec.symbol_length = 4'(n);
            end
            KIND_ADD: begin
              rec.has_mpid = (mtype == CH_F);
              rec.stock_locate = locate;
              rec.order_ref = ref_old;
              rec.sell_side = (side_chr != CH_B);
              rec.share_count = shares;
              rec.order_price = price;
              bump = 1'b1;
              sidx = ST_ADD;
            end
            KIND_EXEC, KIND_EXEC_PX: begin
              rec.order_ref = ref_old;
              rec.share_count = shares;
              stat_count[ST_TRD] = stat_count[ST_TRD] + 32'd1;
              bump = 1'b1;
              sidx = ST_EXE;
            end
            KIND_CANCEL: begin
              rec.order_ref = ref_old;
              rec.share_count = shares;
              bump = 1'b1;
              sidx = ST_CAN;
            end
            KIND_DELETE: begin
              rec.order_ref = ref_old;
              bump = 1'b1;
              sidx = ST_DEL;
            end
            KIND_REPLACE: begin
              rec.order_ref = ref_old;
              rec.new_order_ref = ref_new;
              rec.share_count = shares;
              rec.order_price = price;
              bump = 1'b1;
              sidx = ST_REP;
            end
            default: bump = 1'b0;
          endcase
          if (bump) begin
            stat_count[sidx] = stat_count[sidx] + 32'd1;
            rec.kind_total = stat_count[sidx];
          end
          rec.message_total = stat_count[ST_MSG];
          expected_records.push_back(rec);
          phase = LEN_HIGH;
          pos = '0;
        end else begin
          pos = pos + 16'd1;
        end
      end
    endcase
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Record %0d: %s expected %h, got %h", records_checked, name, want, got);
    end
  endtask

  task automatic start_body(input logic [7:0] t, input int len, input int fill);
    int i;
    body_buf.delete();
    if (len > 0) body_buf.push_back(t);
    for (i = 1; i < len; i++) begin
      if (fill == FILL_ZERO) body_buf.push_back(8'h00);
      else if (fill == FILL_ONES) body_buf.push_back(8'hFF);
      else body_buf.push_back(8'($urandom));
    end
  endtask

  task automatic set_symbol(input int nchars, input bit gap);
    int i;
    for (i = 0; i < 8; i++)
      body_buf[11+i] = (i < nchars) ? 8'($urandom_range(8'h41, 8'h5A)) : CH_SPACE;
    if (gap && nchars >= 3) body_buf[12] = CH_SPACE;
  endtask

  task automatic send_body(input int keep);
    logic [15:0] hdr;
    int          i;
    hdr = 16'(body_buf.size());
    stream_bytes.push_back(hdr[15:8]);
    stream_bytes.push_back(hdr[7:0]);
    for (i = 0; i < keep; i++) stream_bytes.push_back(body_buf[i]);
    bytes_queued += keep + 2;
  endtask

  task automatic queue_plain(input logic [7:0] t, input int len, input int fill);
    start_body(t, len, fill);
    send_body(body_buf.size());
  endtask

  assign may_idle = !(bytes_taken >= 1000 && bytes_taken < 1400);

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_taken) begin
        if (stream_bytes.size() != 0 && !(may_idle && $urandom_range(0, 99) < 10)) begin
          data_byte <= stream_bytes.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= !(may_idle && $urandom_range(0, 99) < 10);
    end
  end

  always @(posedge clk) begin : monitor
    decoded_t want;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (expected_records.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected record with message_total %0d", message_total);
        end else begin
          want = expected_records.pop_front();
          records_checked++;
          kind_hits[want.msg_kind]++;
          compare_field("msg_kind", 64'(want.msg_kind), 64'(msg_kind));
          compare_field("has_mpid", 64'(want.has_mpid), 64'(has_mpid));
          compare_field("stock_locate", 64'(want.stock_locate), 64'(stock_locate));
          compare_field("order_ref", want.order_ref, order_ref);
          compare_field("new_order_ref", want.new_order_ref, new_order_ref);
          compare_field("sell_side", 64'(want.sell_side), 64'(sell_side));
          compare_field("share_count", 64'(want.share_count), 64'(share_count));
          compare_field("order_price", 64'(want.order_price), 64'(order_price));
          compare_field("symbol_text", want.symbol_text, symbol_text);
          compare_field("symbol_length", 64'(want.symbol_length), 64'(symbol_length));
          compare_field("message_total", 64'(want.message_total), 64'(message_total));
          compare_field("kind_total", 64'(want.kind_total), 64'(kind_total));
        end
      end
      if (in_valid && in_ready) begin
        decode_byte(data_byte);
        bytes_taken++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("No transfer for %0d cycles, giving up.", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    int          start;
    int          len;
    int          r;
    int          i;
    logic [7:0]  t;
    logic [15:0] min;
    rst = 1'b1;
    in_valid = 1'b0;
    out_ready = 1'b0;
    data_byte = 8'h00;
    for (i = 0; i < NUM_STATS; i++) stat_count[i] = '0;
    for (i = 0; i < 8; i++) kind_hits[i] = 0;

    queue_plain(8'h00, 0, FILL_RANDOM);
    queue_plain(CH_A, 1, FILL_RANDOM);
    start_body(CH_R, MIN_LEN_R, FILL_RANDOM); set_symbol(4, 0); send_body(body_buf.size());
    start_body(CH_R, MIN_LEN_R, FILL_ZERO); set_symbol(0, 0); send_body(body_buf.size());
    queue_plain(CH_R, 45, FILL_ONES);
    start_body(CH_R, MIN_LEN_R, FILL_RANDOM); set_symbol(8, 0); send_body(body_buf.size());
    start_body(CH_R, MIN_LEN_R, FILL_RANDOM); set_symbol(5, 1); send_body(body_buf.size());
    queue_plain(CH_R, MIN_LEN_R - 1, FILL_RANDOM);
    start_body(CH_A, MIN_LEN_A, FILL_ONES); body_buf[19] = CH_B; send_body(body_buf.size());
    queue_plain(CH_A, MIN_LEN_A, FILL_ZERO);
    start_body(CH_F, MIN_LEN_F, FILL_RANDOM); body_buf[19] = CH_B; send_body(body_buf.size());
    queue_plain(CH_A, MIN_LEN_A - 1, FILL_RANDOM);
    queue_plain(CH_F, MIN_LEN_F - 1, FILL_RANDOM);
    queue_plain(CH_E, MIN_LEN_E, FILL_RANDOM);
    queue_plain(CH_E, MIN_LEN_E - 1, FILL_RANDOM);
    queue_plain(CH_C, MIN_LEN_C, FILL_ONES);
    queue_plain(CH_C, MIN_LEN_C - 1, FILL_RANDOM);
    queue_plain(CH_X, MIN_LEN_X, FILL_RANDOM);
    queue_plain(CH_X, MIN_LEN_X - 1, FILL_RANDOM);
    queue_plain(CH_D, MIN_LEN_D, FILL_RANDOM);
    queue_plain(CH_D, MIN_LEN_D - 1, FILL_RANDOM);
    queue_plain(CH_U, MIN_LEN_U, FILL_ONES);
    queue_plain(CH_U, MIN_LEN_U - 1, FILL_RANDOM);
    queue_plain(8'h53, 12, FILL_RANDOM);
    queue_plain(8'hFF, 40, FILL_ONES);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    do begin
      @(posedge clk);
      #1;
    end while (stream_bytes.size() != 0 || (in_valid && !in_taken) ||
               expected_records.size() != 0);

    start = bytes_queued;
    while (bytes_queued - start < RANDOM_BYTES) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        queue_plain(8'h00, 0, FILL_RANDOM);
      end else if (r < 9) begin
        do t = 8'($urandom);
        while (t == CH_R || t == CH_A || t == CH_F || t == CH_E ||
               t == CH_C || t == CH_X || t == CH_D || t == CH_U);
        queue_plain(t, $urandom_range(1, 45), FILL_RANDOM);
      end else begin
        case ($urandom_range(0, 7))
          0: begin t = CH_R; min = MIN_LEN_R; end
          1: begin t = CH_A; min = MIN_LEN_A; end
          2: begin t = CH_F; min = MIN_LEN_F; end
          3: begin t = CH_E; min = MIN_LEN_E; end
          4: begin t = CH_C; min = MIN_LEN_C; end
          5: begin t = CH_X; min = MIN_LEN_X; end
          6: begin t = CH_D; min = MIN_LEN_D; end
          default: begin t = CH_U; min = MIN_LEN_U; end
        endcase
        r = $urandom_range(0, 99);
        if (r < 12) len = $urandom_range(1, min - 1);
        else if (r < 14) len = $urandom_range(256, 400);
        else len = min + $urandom_range(0, 4);
        r = $urandom_range(0, 19);
        start_body(t, len, (r == 0) ? FILL_ZERO : (r == 1) ? FILL_ONES : FILL_RANDOM);
        if (t == CH_R && len >= 19 && $urandom_range(0, 3) != 0)
          set_symbol($urandom_range(0, 8), 1'($urandom_range(0, 1)));
        if ((t == CH_A || t == CH_F) && len >= 20 && $urandom_range(0, 1) == 1)
          body_buf[19] = CH_B;
        send_body(body_buf.size());
      end
    end

    // The stream ends inside an add body, which must never yield a record.
    start_body(CH_A, MIN_LEN_A + 4, FILL_RANDOM);
    send_body(12);

    do begin
      @(posedge clk);
      #1;
    end while (stream_bytes.size() != 0 || (in_valid && !in_taken) ||
               expected_records.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_records.size() != 0) begin
      mismatches += expected_records.size();
      $display("%0d expected records never arrived.", expected_records.size());
    end
    $display("Run covered %0d stream bytes and %0d decoded records, %0d of them mismatched.",
             bytes_taken, records_checked, mismatches);
    $display("Records by kind: ignored %0d, directory %0d, add %0d, exec %0d, exec price %0d, %s",
             kind_hits[0], kind_hits[1], kind_hits[2], kind_hits[3], kind_hits[4],
             $sformatf("cancel %0d, delete %0d, replace %0d.",
                       kind_hits[5], kind_hits[6], kind_hits[7]));
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ itch_message_decoder_top.f @@
sv/itchd_pkg.sv
sv/itchd_parser.sv
sv/itchd_decode.sv
sv/itchd_stats.sv
sv/itch_message_decoder_top.sv
sv/itchd_checker.sv
tb/sv/itch_message_decoder_top_test.sv
